>>> rtl/cbm_pkg.sv
// cartridge bank mapper: shared codes, field widths and the stage-one item type
// no dependencies; imported by cbm_xlate and the top level
package cbm_pkg;

	localparam int unsigned OFS_W = 22;

	localparam logic [2:0] OP_REG_WR  = 3'd0;
	localparam logic [2:0] OP_CHR_RD  = 3'd1;
	localparam logic [2:0] OP_PRG_RD  = 3'd2;
	localparam logic [2:0] OP_RAM_RD  = 3'd3;
	localparam logic [2:0] OP_RAM_WR  = 3'd4;
	localparam logic [2:0] OP_TICK    = 3'd5;

	localparam logic [2:0] KIND_NONE   = 3'd0;
	localparam logic [2:0] KIND_CHR    = 3'd1;
	localparam logic [2:0] KIND_PRG    = 3'd2;
	localparam logic [2:0] KIND_RAM_RD = 3'd3;
	localparam logic [2:0] KIND_RAM_WR = 3'd4;

	localparam logic [7:0] CFG_IDX_PRG_UNITS = 8'd0;
	localparam logic [7:0] CFG_IDX_RAM_BASE  = 8'd1;

	typedef enum logic [1:0] {
		PRG_BASE_BANK,
		PRG_BASE_LAST,
		PRG_BASE_SECOND
	} prg_base_t;

	typedef struct packed {
		logic [2:0]  kind;
		prg_base_t   prg_base;
		logic        chr_inc;
		logic [12:0] low13;
		logic [7:0]  pass;
		logic        irq;
		logic        mirror;
	} xl_item_t;

endpackage

>>> rtl/cbm_xlate.sv
// cartridge bank mapper: offset translation from a bank register read and the item
// depends on cbm_pkg
module cbm_xlate (
	input  cbm_pkg::xl_item_t         item,
	input  logic [7:0]                bank,
	input  logic [7:0]                prg_units,
	input  logic [15:0]               ram_base,
	output logic [cbm_pkg::OFS_W-1:0] offset
);
	import cbm_pkg::*;

	logic [8:0]       chr_bank;
	logic [OFS_W-1:0] rom_size;
	logic [OFS_W-1:0] prg_base;

	always_comb begin
		chr_bank = {1'b0, bank} + {8'd0, item.chr_inc};
		rom_size = {item.kind == KIND_NONE ? 8'd0 : prg_units, 14'd0};
		case (item.prg_base)
			PRG_BASE_LAST:   prg_base = rom_size - OFS_W'(8192);
			PRG_BASE_SECOND: prg_base = rom_size - OFS_W'(16384);
			default:         prg_base = {1'b0, bank, 13'd0};
		endcase
		case (item.kind)
			KIND_CHR:    offset = {3'd0, chr_bank, item.low13[9:0]};
			KIND_PRG:    offset = prg_base + {9'd0, item.low13};
			KIND_RAM_RD,
			KIND_RAM_WR: offset = {6'd0, ram_base} + {9'd0, item.low13};
			default:     offset = '0;
		endcase
	end

endmodule

>>> rtl/cartridge_bank_mapper_with_line_irq_unit.sv
// cartridge bank mapper with scanline interrupt counter: top level
// depends on cbm_pkg and cbm_xlate
//
//   channel  direction  transfer when           carries
//   s_*      in         s_tvalid & s_tready     bus access, register write or tick
//   m_*      out        m_tvalid & m_tready     translated access and status
//   cfg_*    in         cfg_valid & cfg_ready   program rom size, ram window base
//
// one item per cycle unless m_tready stalls; stage 1 feeds the output register
// stage 0 updates the control registers and reads the bank register memory,
// stage 1 translates the offset from the registered read data
// reset loads control register defaults, clears bank valid bits; no clearing pass
// with m_tready low the output register holds, and s_tready falls once
// stage 1 is also full; cfg_ready is always high
module cartridge_bank_mapper_with_line_irq_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // address[15:0], write_data[23:16]
	input  logic [2:0]  s_tuser,   // operation[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // target_offset[21:0], pass_data[29:22],
	                               // irq_request[30], mirror_horizontal[31]
	output logic [2:0]  m_tuser,   // access_kind[2:0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import cbm_pkg::*;

	logic [7:0]  prg_units_q;
	logic [15:0] ram_base_q;
	logic [7:0]  bank_select_q;
	logic        mirror_q;
	logic        ram_en_q;
	logic        ram_wp_q;
	logic [7:0]  irq_reload_q;
	logic [7:0]  irq_cnt_q;
	logic        irq_en_q;

	logic [7:0] bank_mem [8];
	logic [7:0] bank_vld_q;

	logic       valid_s1;
	xl_item_t   item_s1;
	logic [7:0] rdata_s1;
	logic       rvld_s1;

	logic             out_valid_q;
	logic [2:0]       out_kind_q;
	logic [OFS_W-1:0] out_ofs_q;
	logic [7:0]       out_pass_q;
	logic             out_irq_q;
	logic             out_mirror_q;

	logic [2:0]  op;
	logic [15:0] addr;
	logic [7:0]  wdata;
	logic        acc;
	logic        ready_s1;
	logic        in_ram;
	logic [2:0]  chr_slot;
	logic [1:0]  prg_slot;
	logic [2:0]  raddr;
	logic        bank_wr;
	logic [7:0]  bank_wdata;
	logic [7:0]  cnt_nxt;
	xl_item_t    item_s0;
	logic [7:0]  bank_s1;
	logic [OFS_W-1:0] ofs_s1;

	assign op    = s_tuser;
	assign addr  = s_tdata[15:0];
	assign wdata = s_tdata[23:16];

	assign ready_s1  = !out_valid_q || m_tready;
	assign s_tready  = !valid_s1 || ready_s1;
	assign acc       = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	always_comb begin
		in_ram     = addr[15:13] == 3'b011;
		chr_slot   = addr[12:10] ^ {bank_select_q[7], 2'b00};
		prg_slot   = addr[14:13];
		raddr      = '0;
		bank_wr    = 1'b0;
		bank_wdata = wdata;
		cnt_nxt    = (irq_cnt_q == 8'd0) ? irq_reload_q : irq_cnt_q - 8'd1;

		item_s0          = '0;
		item_s0.kind     = KIND_NONE;
		item_s0.prg_base = PRG_BASE_BANK;
		item_s0.low13    = addr[12:0];
		item_s0.mirror   = mirror_q;

		unique case (op)
			OP_REG_WR: begin
				if (addr[15:13] == 3'b100 && addr[0]) begin
					bank_wr = 1'b1;
					raddr   = bank_select_q[2:0];
					if (bank_select_q[2:1] == 2'b00)
						bank_wdata = wdata & 8'hFE;
					else if (bank_select_q[2:1] == 2'b11)
						bank_wdata = wdata & 8'h3F;
				end
				if (addr[15:13] == 3'b101 && !addr[0])
					item_s0.mirror = wdata[0];
			end
			OP_CHR_RD: begin
				if (addr < 16'h2000) begin
					item_s0.kind = KIND_CHR;
					if (!chr_slot[2]) begin
						raddr           = {2'b00, chr_slot[1]};
						item_s0.chr_inc = chr_slot[0];
					end else begin
						raddr = chr_slot - 3'd2;
					end
				end
			end
			OP_PRG_RD: begin
				if (addr[15]) begin
					item_s0.kind = KIND_PRG;
					if (prg_slot == 2'd1)
						raddr = 3'd7;
					else if (prg_slot == 2'd3)
						item_s0.prg_base = PRG_BASE_LAST;
					else if ((prg_slot == 2'd0) != bank_select_q[6])
						raddr = 3'd6;
					else
						item_s0.prg_base = PRG_BASE_SECOND;
				end
			end
			OP_RAM_RD: begin
				if (in_ram && ram_en_q)
					item_s0.kind = KIND_RAM_RD;
			end
			OP_RAM_WR: begin
				if (in_ram && ram_en_q && !ram_wp_q) begin
					item_s0.kind = KIND_RAM_WR;
					item_s0.pass = wdata;
				end
			end
			OP_TICK: begin
				item_s0.irq = (cnt_nxt == 8'd0) && irq_en_q;
			end
			default: begin
			end
		endcase
	end

	// control registers, updated as each item is taken and on each config transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prg_units_q   <= 8'd2;
			ram_base_q    <= '0;
			bank_select_q <= '0;
			mirror_q      <= 1'b0;
			ram_en_q      <= 1'b1;
			ram_wp_q      <= 1'b0;
			irq_reload_q  <= '0;
			irq_cnt_q     <= '0;
			irq_en_q      <= 1'b0;
			bank_vld_q    <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_IDX_PRG_UNITS)
					prg_units_q <= cfg_data[7:0];
				else if (cfg_index == CFG_IDX_RAM_BASE)
					ram_base_q <= cfg_data;
			end
			if (acc && bank_wr)
				bank_vld_q[raddr] <= 1'b1;
			if (acc && op == OP_TICK)
				irq_cnt_q <= cnt_nxt;
			if (acc && op == OP_REG_WR && addr[15]) begin
				unique case ({addr[14:13], addr[0]})
					3'b000: bank_select_q <= wdata;
					3'b010: mirror_q      <= wdata[0];
					3'b011: begin
						ram_en_q <= wdata[7];
						ram_wp_q <= wdata[6];
					end
					3'b100: irq_reload_q <= wdata;
					3'b101: irq_cnt_q    <= '0;
					3'b110: irq_en_q     <= 1'b0;
					3'b111: irq_en_q     <= 1'b1;
					default: begin
					end
				endcase
			end
		end
	end

	// bank register memory: one write, one registered read per cycle, on cycles where an item is taken
	always_ff @(posedge clk) begin
		if (acc) begin
			if (bank_wr)
				bank_mem[raddr] <= bank_wdata;
			rdata_s1 <= bank_mem[raddr];
			rvld_s1  <= bank_vld_q[raddr];
			item_s1  <= item_s0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tready)
			valid_s1 <= s_tvalid;
	end

	assign bank_s1 = rvld_s1 ? rdata_s1 : 8'd0;

	cbm_xlate u_xlate (
		.item      (item_s1),
		.bank      (bank_s1),
		.prg_units (prg_units_q),
		.ram_base  (ram_base_q),
		.offset    (ofs_s1)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (ready_s1)
			out_valid_q <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && valid_s1) begin
			out_kind_q   <= item_s1.kind;
			out_ofs_q    <= ofs_s1;
			out_pass_q   <= item_s1.pass;
			out_irq_q    <= item_s1.irq;
			out_mirror_q <= item_s1.mirror;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_kind_q;
	assign m_tdata  = {out_mirror_q, out_irq_q, out_pass_q, out_ofs_q};

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !ready_s1 |=> valid_s1 && $stable(item_s1))
		else $error("stage 1 item lost under stall");

	a_no_accept_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> valid_s1 && out_valid_q)
		else $error("input stalled with free pipeline space");

	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_NONE |-> m_tdata[29:0] == 30'd0)
		else $error("offset or data set without an access");

	a_pass_wr: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[29:22] != 8'd0 |-> m_tuser == KIND_RAM_WR)
		else $error("pass data on a non-write access");

endmodule
